// File: rtl/ust_pkg.sv
`default_nettype none

package ust_pkg;

    localparam int NUM_W = 16;

    // operation codes carried in the input transfer
    typedef enum logic [1:0] {
        OP_BOOK   = 2'd0,
        OP_CANCEL = 2'd1,
        OP_SEARCH = 2'd2,
        OP_LIST   = 2'd3
    } op_t;

    // result status codes
    typedef enum logic [3:0] {
        ST_BOOKED    = 4'd0,
        ST_DUPLICATE = 4'd1,
        ST_FULL      = 4'd2,
        ST_CANCELLED = 4'd3,
        ST_NOT_FOUND = 4'd4,
        ST_PRESENT   = 4'd5,
        ST_ABSENT    = 4'd6,
        ST_ENTRY     = 4'd7,
        ST_EMPTY     = 4'd8
    } status_t;

    // one result from the engine to the output register
    typedef struct packed {
        status_t            status;
        logic [NUM_W-1:0]   value;
        logic               last;
    } res_t;

endpackage

`default_nettype wire

// File: rtl/ust_ram.sv
`default_nettype none

module ust_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: rtl/ust_engine.sv
`default_nettype none

module ust_engine
    import ust_pkg::*;
#(
    parameter int CAPACITY = 32,
    localparam int CW = $clog2(CAPACITY + 1)
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire op_t              in_op,
    input  wire logic [NUM_W-1:0] in_num,
    output logic                  res_valid,
    input  wire logic             res_ready,
    output res_t                  res,
    output logic      [CW-1:0]    fill
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_SCAN     = 6'b000010,
        S_SHIFT    = 6'b000100,
        S_LIST_RD  = 6'b001000,
        S_LIST_OUT = 6'b010000,
        S_RESULT   = 6'b100000
    } state_t;

    state_t           state_reg, state_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [CW-1:0]    idx_reg, idx_next;
    logic [CW-1:0]    rd_idx_reg, rd_idx_next;
    logic             rd_vld_reg, rd_vld_next;
    op_t              op_reg, op_next;
    logic [NUM_W-1:0] num_reg, num_next;
    res_t             out_reg, out_next;

    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic [NUM_W-1:0] rd_data;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [NUM_W-1:0] wr_data;

    logic [CW-1:0]    last_idx;
    logic [CW-1:0]    prev_idx;

    assign last_idx = cnt_reg - CW'(1);
    assign prev_idx = rd_idx_reg - CW'(1);

    ust_ram #(
        .WIDTH (NUM_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        idx_next    = idx_reg;
        rd_idx_next = rd_idx_reg;
        rd_vld_next = 1'b0;
        op_next     = op_reg;
        num_next    = num_reg;
        out_next    = out_reg;
        rd_en       = 1'b0;
        rd_addr     = idx_reg[AW-1:0];
        wr_en       = 1'b0;
        wr_addr     = cnt_reg[AW-1:0];
        wr_data     = num_reg;
        in_ready    = (state_reg == S_IDLE);
        res_valid   = 1'b0;
        res         = out_reg;

        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    op_next        = in_op;
                    num_next       = in_num;
                    out_next.value = in_num;
                    out_next.last  = 1'b1;
                    idx_next       = '0;
                    if (in_op == OP_BOOK && cnt_reg == CW'(CAPACITY)) begin
                        out_next.status = ST_FULL;
                        state_next      = S_RESULT;
                    end else if (in_op == OP_LIST) begin
                        if (cnt_reg == '0) begin
                            out_next.status = ST_EMPTY;
                            out_next.value  = '0;
                            state_next      = S_RESULT;
                        end else begin
                            state_next = S_LIST_RD;
                        end
                    end else if (cnt_reg == '0) begin
                        // nothing stored: no scan needed
                        state_next = S_RESULT;
                        case (in_op)
                            OP_BOOK: begin
                                wr_en           = 1'b1;
                                wr_addr         = '0;
                                wr_data         = in_num;
                                cnt_next        = CW'(1);
                                out_next.status = ST_BOOKED;
                            end
                            OP_CANCEL: out_next.status = ST_NOT_FOUND;
                            default:   out_next.status = ST_ABSENT;
                        endcase
                    end else begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN: begin
                // read one entry per cycle, compare it the cycle after
                rd_en       = (idx_reg < cnt_reg);
                rd_vld_next = rd_en;
                rd_idx_next = idx_reg;
                if (rd_en) begin
                    idx_next = idx_reg + CW'(1);
                end
                if (rd_vld_reg) begin
                    if (rd_data == num_reg) begin
                        rd_vld_next = 1'b0;
                        state_next  = S_RESULT;
                        case (op_reg)
                            OP_BOOK:   out_next.status = ST_DUPLICATE;
                            OP_SEARCH: out_next.status = ST_PRESENT;
                            OP_CANCEL: begin
                                out_next.status = ST_CANCELLED;
                                if (rd_idx_reg == last_idx) begin
                                    cnt_next = last_idx;
                                end else begin
                                    idx_next   = rd_idx_reg + CW'(1);
                                    state_next = S_SHIFT;
                                end
                            end
                            default: out_next.status = ST_ABSENT;
                        endcase
                    end else if (rd_idx_reg == last_idx) begin
                        rd_vld_next = 1'b0;
                        state_next  = S_RESULT;
                        case (op_reg)
                            OP_BOOK: begin
                                wr_en           = 1'b1;
                                cnt_next        = cnt_reg + CW'(1);
                                out_next.status = ST_BOOKED;
                            end
                            OP_CANCEL: out_next.status = ST_NOT_FOUND;
                            default:   out_next.status = ST_ABSENT;
                        endcase
                    end
                end
            end

            S_SHIFT: begin
                // read entry k+1, write it back to k
                rd_en       = (idx_reg < cnt_reg);
                rd_vld_next = rd_en;
                rd_idx_next = idx_reg;
                if (rd_en) begin
                    idx_next = idx_reg + CW'(1);
                end
                if (rd_vld_reg) begin
                    wr_en   = 1'b1;
                    wr_addr = prev_idx[AW-1:0];
                    wr_data = rd_data;
                    if (rd_idx_reg == last_idx) begin
                        rd_vld_next = 1'b0;
                        cnt_next    = last_idx;
                        state_next  = S_RESULT;
                    end
                end
            end

            S_LIST_RD: begin
                rd_en      = 1'b1;
                state_next = S_LIST_OUT;
            end

            S_LIST_OUT: begin
                res_valid  = 1'b1;
                res.status = ST_ENTRY;
                res.value  = rd_data;
                res.last   = (idx_reg == last_idx);
                if (res_ready) begin
                    if (idx_reg == last_idx) begin
                        state_next = S_IDLE;
                    end else begin
                        idx_next   = idx_reg + CW'(1);
                        state_next = S_LIST_RD;
                    end
                end
            end

            S_RESULT: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            rd_vld_reg <= rd_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg    <= idx_next;
        rd_idx_reg <= rd_idx_next;
        op_reg     <= op_next;
        num_reg    <= num_next;
        out_reg    <= out_next;
    end

    assign fill = cnt_reg;

endmodule

`default_nettype wire

// File: rtl/unordered_set_table_top.sv
`default_nettype none

// Channel   Dir  Ports                       Payload
// s_        in   s_tvalid/s_tready/s_tdata   func, seat_number
// m_        out  m_tvalid/m_tready/m_tdata   status, entry_value; last on m_tlast
//
// Book, cancel and search scan the stored entries in order (one RAM read per
// cycle, compared the cycle after); a miss scans every entry, a hit ends the
// scan, and a cancel hit with entries behind it shifts them down. List reads
// each entry, then presents it. Empty table or full book: no scan.
// aresetn (synchronous, active low) empties the table; the RAM is not cleared.
// A stalled m_ side holds the engine; s_tready rises once the last result moves.

module unordered_set_table_top
    import ust_pkg::*;
#(
    parameter int CAPACITY = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // [1:0] func, [17:2] seat_number
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [23:0] m_tdata,   // [3:0] status, [19:4] entry_value
    output logic             m_tlast
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic          res_valid;
    logic          res_ready;
    res_t          res;
    logic [CW-1:0] fill;

    logic          m_tvalid_reg;
    res_t          m_res_reg;

    ust_engine #(
        .CAPACITY (CAPACITY)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (op_t'(s_tdata[1:0])),
        .in_num    (s_tdata[17:2]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .fill      (fill)
    );

    // output register: takes a new result when empty or being drained
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_ready) begin
            m_tvalid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0000, m_res_reg.value, m_res_reg.status};
    assign m_tlast  = m_res_reg.last;

    // every accepted transfer takes the engine out of idle
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("s_tready high right after an accepted transfer");

    // table never holds more than its capacity
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill <= CW'(CAPACITY))
        else $error("fill count beyond capacity");

    // only list entries may be non-final results
    a_last_only_list: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> (m_res_reg.status == ST_ENTRY))
        else $error("non-final result that is not a list entry");

endmodule

`default_nettype wire

// File: bench/tb.sv
`timescale 1ns / 1ps

module tb;
    import ust_pkg::*;

    localparam int CAPACITY = 32;
    localparam int SHOW_LIMIT = 10;     // mismatches printed in full
    localparam int DRAIN_CYCLES = 100;  // settle time after the last reply

    // one table command as the driver sends it
    typedef struct {
        op_t              func;
        logic [NUM_W-1:0] num;
    } table_cmd_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;   // [1:0] func, [17:2] seat_number
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;         // [3:0] status, [19:4] entry_value
    logic        m_tlast;

    unordered_set_table_top #(
        .CAPACITY (CAPACITY)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // commands waiting for the driver, replies waiting for the monitor
    table_cmd_t command_queue[$];
    res_t       table_replies[$];

    // shadow of the table contents, insertion order
    logic [NUM_W-1:0] seats[CAPACITY];
    int               seat_count = 0;

    // idle / stall rates in percent, changed per phase
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    int mismatch_count = 0;

    // pool of numbers reused often, so hits, duplicates and a full table occur
    localparam int POOL_SIZE = 40;
    logic [NUM_W-1:0] seat_pool[POOL_SIZE];

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Apply one command to the shadow table and queue the replies it causes.
    task automatic apply_table_op(input op_t func, input logic [NUM_W-1:0] num);
        int   pos;
        res_t r;
        // first match, or seat_count when absent
        pos = seat_count;
        for (int k = seat_count - 1; k >= 0; k--)
            if (seats[k] == num) pos = k;
        r.value = num;
        r.last  = 1'b1;
        case (func)
            OP_BOOK: begin
                // a full table wins over the duplicate check
                if (seat_count >= CAPACITY) begin
                    r.status = ST_FULL;
                end else if (pos < seat_count) begin
                    r.status = ST_DUPLICATE;
                end else begin
                    seats[seat_count] = num;
                    seat_count++;
                    r.status = ST_BOOKED;
                end
            end
            OP_CANCEL: begin
                if (pos < seat_count) begin
                    // close the gap behind the removed entry
                    for (int k = pos; k + 1 < seat_count; k++)
                        seats[k] = seats[k + 1];
                    seat_count--;
                    r.status = ST_CANCELLED;
                end else begin
                    r.status = ST_NOT_FOUND;
                end
            end
            OP_SEARCH: begin
                r.status = (pos < seat_count) ? ST_PRESENT : ST_ABSENT;
            end
            default: begin
                // list: one reply per entry, or a single empty marker
                if (seat_count == 0) begin
                    r.status = ST_EMPTY;
                    r.value  = '0;
                end else begin
                    for (int k = 0; k < seat_count; k++) begin
                        r.status = ST_ENTRY;
                        r.value  = seats[k];
                        r.last   = (k + 1 == seat_count);
                        table_replies.push_back(r);
                    end
                end
            end
        endcase
        if (func != OP_LIST || seat_count == 0)
            table_replies.push_back(r);
    endtask

    // ------------------------------------------------------------------
    // Driver: presents the next queued command, holds it until the
    // transfer, and predicts the replies at the accepting edge.
    // ------------------------------------------------------------------
    table_cmd_t drv_cmd;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end else begin
            if (s_tvalid && s_tready)
                apply_table_op(drv_cmd.func, drv_cmd.num);
            // free to load a new command unless one is still waiting
            if (!s_tvalid || s_tready) begin
                if (command_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    drv_cmd  = command_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {6'b0, drv_cmd.num, drv_cmd.func};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: random back-pressure, and every reply transfer is checked
    // against the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        res_t want;
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
        if (aresetn && m_tvalid && m_tready) begin
            if (table_replies.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= SHOW_LIMIT)
                    $display("unexpected reply: status %0d value %h last %b",
                             m_tdata[3:0], m_tdata[19:4], m_tlast);
            end else begin
                want = table_replies.pop_front();
                if (m_tdata[3:0] !== want.status || m_tdata[19:4] !== want.value
                        || m_tlast !== want.last) begin
                    mismatch_count++;
                    if (mismatch_count <= SHOW_LIMIT)
                        $display("reply mismatch: exp status %0d value %h last %b, got status %0d value %h last %b",
                                 want.status, want.value, want.last,
                                 m_tdata[3:0], m_tdata[19:4], m_tlast);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_cmd(input op_t func, input logic [NUM_W-1:0] num);
        table_cmd_t c;
        c.func = func;
        c.num  = num;
        command_queue.push_back(c);
    endtask

    // mixed traffic, mostly pool numbers so the table state matters
    task automatic queue_random(input int n);
        int               r;
        logic [NUM_W-1:0] num;
        for (int i = 0; i < n; i++) begin
            r   = $urandom_range(99);
            num = ($urandom_range(99) < 70) ? seat_pool[$urandom_range(POOL_SIZE - 1)]
                                            : NUM_W'($urandom);
            if (r < 40)      push_cmd(OP_BOOK, num);
            else if (r < 60) push_cmd(OP_CANCEL, num);
            else if (r < 85) push_cmd(OP_SEARCH, num);
            else             push_cmd(OP_LIST, num);
        end
    endtask

    // fill the table with distinct numbers, overflow it, list it full,
    // then punch holes and look things up
    task automatic queue_fill_burst();
        logic [NUM_W-1:0] base;
        base = NUM_W'($urandom);
        for (int k = 0; k < CAPACITY + 4; k++)
            push_cmd(OP_BOOK, base + NUM_W'(k * 37));
        push_cmd(OP_BOOK, base);              // held number on a full table
        push_cmd(OP_LIST, NUM_W'($urandom));  // widest reply burst
        for (int k = 0; k < 6; k++)
            push_cmd(OP_CANCEL, base + NUM_W'($urandom_range(CAPACITY - 1) * 37));
        push_cmd(OP_SEARCH, base + NUM_W'(37));
        push_cmd(OP_LIST, NUM_W'($urandom));
    endtask

    // sender holds off until every predicted reply has come back
    task automatic wait_idle();
        while (command_queue.size() > 0 || s_tvalid || table_replies.size() > 0)
            @(negedge aclk);
    endtask

    task automatic set_rates(input int idle_pct, input int stall_pct);
        @(negedge aclk);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
    endtask

    // ------------------------------------------------------------------
    // Run sequence
    // ------------------------------------------------------------------
    initial begin
        seat_pool[0] = '0;
        seat_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++)
            seat_pool[i] = NUM_W'($urandom);

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty table, edge values, duplicates, removal at
        // head and tail, list ignoring its number
        set_rates(0, 0);
        push_cmd(OP_LIST,   16'hBEEF);   // empty marker, value forced to 0
        push_cmd(OP_CANCEL, 16'h0000);   // not found on empty table
        push_cmd(OP_SEARCH, 16'h0000);
        push_cmd(OP_BOOK,   16'h0000);
        push_cmd(OP_BOOK,   16'hFFFF);
        push_cmd(OP_BOOK,   16'h0000);   // duplicate
        push_cmd(OP_SEARCH, 16'hFFFF);
        push_cmd(OP_SEARCH, 16'h1234);
        push_cmd(OP_BOOK,   16'h5555);
        push_cmd(OP_BOOK,   16'hAAAA);
        push_cmd(OP_LIST,   16'hFFFF);
        push_cmd(OP_CANCEL, 16'h0000);   // head entry, rest shifts down
        push_cmd(OP_CANCEL, 16'hAAAA);   // tail entry
        push_cmd(OP_CANCEL, 16'h0001);
        push_cmd(OP_LIST,   16'h0000);
        push_cmd(OP_CANCEL, 16'hFFFF);
        push_cmd(OP_CANCEL, 16'h5555);   // table empty again
        push_cmd(OP_LIST,   16'h1234);
        push_cmd(OP_SEARCH, 16'h5555);
        push_cmd(OP_BOOK,   16'h8001);
        queue_random(32);
        wait_idle();

        // sender gaps, with a full-table burst
        set_rates(47, 0);
        queue_fill_burst();
        queue_random(32);
        wait_idle();

        // receiver back-pressure
        set_rates(0, 47);
        queue_random(32);
        wait_idle();

        // both sides irregular, second full-table burst
        set_rates(34, 34);
        queue_fill_burst();
        queue_random(32);
        wait_idle();

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && table_replies.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

    // hard stop far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("tb NOT OK");
        $finish;
    end

endmodule
